// ===== design/ppmbsr_pkg.sv =====
`timescale 1ns / 1ps

package ppmbsr_pkg;

  localparam int MAX_W     = 16;
  localparam int DIM_W     = 15;
  localparam int NORM_W    = 17;
  localparam int BYTE_W    = 8;
  localparam int CH_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 2;
  localparam int DIV_STEPS = 17;
  localparam int CNT_W     = 5;

  localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  localparam logic [CH_W-1:0] CH_RED  = 2'd0;
  localparam logic [CH_W-1:0] CH_BLUE = 2'd2;

  localparam logic [MAX_W-1:0] MAX_VALUE_RST = 16'd255;
  localparam logic [DIM_W-1:0] DIM_RST       = 15'd1;

  typedef struct packed {
    logic take_in;
    logic decode;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic res_valid;
    logic res_div;
  } sts_t;

endpackage

// ===== design/ppm_binary_sample_reader_unit.sv =====
`timescale 1ns / 1ps
// Binary PPM pixel body reader. Feed the raw body bytes on the in_ channel, one byte per
// word; a word with in_end_of_stream set closes the image and re-arms the reader.
// Each completed sample leaves on the out_ channel with its raw value, its Q1.16
// normalised value, colour channel, pixel index, last flag and status. A value above
// max_value gives one error word and halts the reader until the next end marker.
// Program max_value, image_width and image_height through the cfg_ port (index 0, 1, 2);
// cfg_ready is always high, and writes belong between images while the reader is idle.
// Sequence: a byte that completes a valid sample (nonzero max_value) passes through decode,
// 17 steps of the radix-2 divider and a load into the output register; an error or
// missing-data word skips the divider, and a byte that gives no word returns to idle.
// The reader takes no new byte until it is through with the last one.
// The input is accepted only in the idle state; a finished word waits in the output
// register while the next byte is taken and decoded. When out_stall is high the word
// holds and the reader stops before loading the next word.
// Reset (rst_n low, synchronous) restores max_value 255, a 1 x 1 image, clears the
// counters and empties the output register.

module ppm_binary_sample_reader_unit #(
  parameter int PIXEL_INDEX_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppmbsr_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [ppmbsr_pkg::MAX_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ppmbsr_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                                in_end_of_stream,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ppmbsr_pkg::MAX_W-1:0]        out_sample_value,
  output logic [ppmbsr_pkg::NORM_W-1:0]       out_normalized_value,
  output logic [ppmbsr_pkg::CH_W-1:0]         out_color_channel,
  output logic [PIXEL_INDEX_BITS-1:0]         out_pixel_index,
  output logic                                out_last_sample,
  output logic [ppmbsr_pkg::STATUS_W-1:0]     out_status
);

  ppmbsr_pkg::cmd_t cmd;
  ppmbsr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ppmbsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppmbsr_dp #(
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_data_byte         (in_data_byte),
    .in_end_of_stream     (in_end_of_stream),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_sample_value     (out_sample_value),
    .out_normalized_value (out_normalized_value),
    .out_color_channel    (out_color_channel),
    .out_pixel_index      (out_pixel_index),
    .out_last_sample      (out_last_sample),
    .out_status           (out_status)
  );

endmodule

// ===== design/ppmbsr_ctrl.sv =====
`timescale 1ns / 1ps

module ppmbsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ppmbsr_pkg::sts_t  sts,
  output ppmbsr_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [ppmbsr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        cnt_nxt    = '0;
        if (!sts.res_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.res_div) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == ppmbsr_pkg::CNT_W'(ppmbsr_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_HOLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/ppmbsr_dp.sv =====
`timescale 1ns / 1ps

module ppmbsr_dp #(
  parameter int PIXEL_INDEX_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [ppmbsr_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [ppmbsr_pkg::MAX_W-1:0]        cfg_data,
  input  logic [ppmbsr_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                                in_end_of_stream,
  input  ppmbsr_pkg::cmd_t                    cmd,
  output ppmbsr_pkg::sts_t                    sts,
  output logic [ppmbsr_pkg::MAX_W-1:0]        out_sample_value,
  output logic [ppmbsr_pkg::NORM_W-1:0]       out_normalized_value,
  output logic [ppmbsr_pkg::CH_W-1:0]         out_color_channel,
  output logic [PIXEL_INDEX_BITS-1:0]         out_pixel_index,
  output logic                                out_last_sample,
  output logic [ppmbsr_pkg::STATUS_W-1:0]     out_status
);

  localparam int PROD_W = 2 * ppmbsr_pkg::DIM_W;
  localparam int TOT_W  = ((PROD_W > PIXEL_INDEX_BITS) ? PROD_W : PIXEL_INDEX_BITS) + 1;

  // configuration
  logic [ppmbsr_pkg::MAX_W-1:0] max_r;
  logic [ppmbsr_pkg::DIM_W-1:0] width_r;
  logic [ppmbsr_pkg::DIM_W-1:0] height_r;

  // sequencing state
  logic                          phase_r;
  logic [ppmbsr_pkg::BYTE_W-1:0] high_r;
  logic [ppmbsr_pkg::CH_W-1:0]   ch_r;
  logic [PIXEL_INDEX_BITS-1:0]   pix_r;
  logic                          halted_r;

  // latched input word
  logic [ppmbsr_pkg::BYTE_W-1:0] byte_r;
  logic                          eos_r;

  // last pixel of the image
  logic [ppmbsr_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic [PROD_W-1:0]             prod;
  logic [TOT_W-1:0]              total, cap, total_c, total_m1;

  // decode
  logic                          wide;
  logic [ppmbsr_pkg::MAX_W-1:0]  sample_c;
  logic                          range_err;
  logic                          is_last;

  // pending result and divider
  logic [ppmbsr_pkg::MAX_W-1:0]    pend_sample_r;
  logic [ppmbsr_pkg::CH_W-1:0]     pend_ch_r;
  logic [PIXEL_INDEX_BITS-1:0]     pend_pix_r;
  logic                            pend_last_r;
  logic [ppmbsr_pkg::STATUS_W-1:0] pend_status_r;
  logic [ppmbsr_pkg::MAX_W-1:0]    divisor_r;
  logic [ppmbsr_pkg::MAX_W-1:0]    rem_r;
  logic                            dvd_bit_r;
  logic [ppmbsr_pkg::NORM_W-1:0]   quo_r;
  logic [ppmbsr_pkg::MAX_W:0]      trial;
  logic [ppmbsr_pkg::MAX_W:0]      trial_sub;
  logic                            trial_ge;

  assign w_eff    = (width_r  == '0) ? ppmbsr_pkg::DIM_W'(1) : width_r;
  assign h_eff    = (height_r == '0) ? ppmbsr_pkg::DIM_W'(1) : height_r;
  assign prod     = PROD_W'(w_eff) * PROD_W'(h_eff);
  assign total    = TOT_W'(prod);
  assign cap      = TOT_W'(1) << PIXEL_INDEX_BITS;
  assign total_c  = (total > cap) ? cap : total;
  assign total_m1 = total_c - TOT_W'(1);

  assign wide      = (max_r[ppmbsr_pkg::MAX_W-1:ppmbsr_pkg::BYTE_W] != '0);
  assign sample_c  = wide ? {high_r, byte_r} : {{ppmbsr_pkg::BYTE_W{1'b0}}, byte_r};
  assign range_err = (sample_c > max_r);
  assign is_last   = (ch_r == ppmbsr_pkg::CH_BLUE) &&
                     (pix_r == total_m1[PIXEL_INDEX_BITS-1:0]);

  assign sts.res_valid = eos_r ? !halted_r : (!halted_r && !(wide && !phase_r));
  assign sts.res_div   = !eos_r && !range_err && (max_r != '0);

  assign trial     = {rem_r, dvd_bit_r};
  assign trial_ge  = (trial >= {1'b0, divisor_r});
  assign trial_sub = trial - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= ppmbsr_pkg::MAX_VALUE_RST;
      width_r  <= ppmbsr_pkg::DIM_RST;
      height_r <= ppmbsr_pkg::DIM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppmbsr_pkg::REG_MAX_VALUE:    max_r    <= cfg_data;
        ppmbsr_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[ppmbsr_pkg::DIM_W-1:0];
        ppmbsr_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data[ppmbsr_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      high_r   <= '0;
      ch_r     <= ppmbsr_pkg::CH_RED;
      pix_r    <= '0;
      halted_r <= 1'b0;
    end else if (cmd.decode) begin
      if (eos_r) begin
        phase_r  <= 1'b0;
        high_r   <= '0;
        ch_r     <= ppmbsr_pkg::CH_RED;
        pix_r    <= '0;
        halted_r <= 1'b0;
      end else if (!halted_r) begin
        if (wide && !phase_r) begin
          high_r  <= byte_r;
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (range_err) begin
            halted_r <= 1'b1;
          end else if (is_last) begin
            high_r   <= '0;
            ch_r     <= ppmbsr_pkg::CH_RED;
            pix_r    <= '0;
            halted_r <= 1'b1;
          end else if (ch_r >= ppmbsr_pkg::CH_BLUE) begin
            ch_r  <= ppmbsr_pkg::CH_RED;
            pix_r <= pix_r + 1'b1;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_stream;
    end
    if (cmd.decode) begin
      pend_sample_r <= eos_r ? '0 : sample_c;
      pend_ch_r     <= ch_r;
      pend_pix_r    <= pix_r;
      pend_last_r   <= !eos_r && !range_err && is_last;
      pend_status_r <= eos_r ? ppmbsr_pkg::STATUS_MISSING :
                       (range_err ? ppmbsr_pkg::STATUS_RANGE : ppmbsr_pkg::STATUS_OK);
      divisor_r     <= max_r;
      rem_r         <= sample_c >> 1;
      dvd_bit_r     <= sample_c[0];
      quo_r         <= '0;
    end else if (cmd.div_step) begin
      dvd_bit_r <= 1'b0;
      if (trial_ge) begin
        rem_r <= trial_sub[ppmbsr_pkg::MAX_W-1:0];
        quo_r <= {quo_r[ppmbsr_pkg::NORM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[ppmbsr_pkg::MAX_W-1:0];
        quo_r <= {quo_r[ppmbsr_pkg::NORM_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_sample_value     <= pend_sample_r;
      out_normalized_value <= quo_r;
      out_color_channel    <= pend_ch_r;
      out_pixel_index      <= pend_pix_r;
      out_last_sample      <= pend_last_r;
      out_status           <= pend_status_r;
    end
  end

endmodule
